// ===== rtl/est_pkg.sv =====
// shared constants, codes and types for the event slot table
`default_nettype none

package est_pkg;

    localparam int ACT_W     = 2;
    localparam int SLOT_W    = 8;
    localparam int DEV_W     = 8;
    localparam int TIME_W    = 64;
    localparam int STAT_W    = 2;
    localparam int CNT_OUT_W = 9;
    localparam int TOTAL_W   = 32;

    // valid marks are kept in rows of this many slots
    localparam int ROW_W  = 16;
    localparam int ROW_BW = 4;

    localparam int DEFAULT_NUM_SLOTS = 256;

    localparam logic [ACT_W-1:0] ACT_CREATE  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DESTROY = 2'd1;
    localparam logic [ACT_W-1:0] ACT_SIGNAL  = 2'd2;
    localparam logic [ACT_W-1:0] ACT_QUERY   = 2'd3;

    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
    localparam logic [STAT_W-1:0] STAT_INVALID = 2'd2;
    localparam logic [STAT_W-1:0] STAT_PENDING = 2'd3;

    typedef struct packed {
        logic              signaled;
        logic [DEV_W-1:0]  owner;
        logic [TIME_W-1:0] stamp;
    } entry_t;

endpackage

`default_nettype wire

// ===== rtl/event_slot_table.sv =====
// event slot table: first-free allocation, destroy, signal and query of event slots
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+-------------------------------------------------
//  request | req_valid | req_stall | action, slot_id, owner_device, time_now
//  response| rsp_valid | rsp_stall | status, result_slot, slot_device, slot_time,
//          |           |           | active_count, created_total, signaled_total
//
//  each request is read at the transfer edge, which reads the valid-mark row memory and the
//  entry memory; the write-back edge writes both back and loads the response register.
//  the response register lets a new request in while the previous response is stalled.
//  rst_n clears counters, per-row full and initialized marks; no clearing pass is needed,
//  an uninitialized row reads as all free.
//  while the response register is full and stalled, the write-back edge waits.
`default_nettype none

module event_slot_table
    import est_pkg::*;
#(
    parameter int NUM_SLOTS = DEFAULT_NUM_SLOTS
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 req_valid,
    output logic                      req_stall,
    input  wire logic [ACT_W-1:0]     action,
    input  wire logic [SLOT_W-1:0]    slot_id,
    input  wire logic [DEV_W-1:0]     owner_device,
    input  wire logic [TIME_W-1:0]    time_now,

    output logic                      rsp_valid,
    input  wire logic                 rsp_stall,
    output logic [STAT_W-1:0]         status,
    output logic [SLOT_W-1:0]         result_slot,
    output logic [DEV_W-1:0]          slot_device,
    output logic [TIME_W-1:0]         slot_time,
    output logic [CNT_OUT_W-1:0]      active_count,
    output logic [TOTAL_W-1:0]        created_total,
    output logic [TOTAL_W-1:0]        signaled_total
);

    localparam int ROWS    = (NUM_SLOTS + ROW_W - 1) / ROW_W;
    localparam int ROW_AW  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int IDX_W   = ROW_AW + ROW_BW;
    localparam int SLOT_AW = $clog2(NUM_SLOTS);
    localparam int CNT_W   = $clog2(NUM_SLOTS + 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg;
    logic state_next;

    // memories
    logic [ROW_W-1:0] row_mem [ROWS];
    entry_t           entry_mem [NUM_SLOTS];
    logic [ROW_W-1:0] row_rd_reg;
    entry_t           entry_rd_reg;

    // per-row marks
    logic [ROWS-1:0]  row_full_reg;
    logic [ROWS-1:0]  row_init_reg;

    // captured request
    logic [ACT_W-1:0]  act_reg;
    logic [SLOT_W-1:0] sid_reg;
    logic [DEV_W-1:0]  dev_reg;
    logic [TIME_W-1:0] now_reg;
    logic              in_range_reg;
    logic              free_found_reg;
    logic [ROW_AW-1:0] row_addr_reg;
    logic              row_live_reg;

    // counters
    logic [CNT_W-1:0]   active_reg;
    logic [CNT_W-1:0]   active_next;
    logic [TOTAL_W-1:0] creates_reg;
    logic [TOTAL_W-1:0] creates_next;
    logic [TOTAL_W-1:0] signals_reg;
    logic [TOTAL_W-1:0] signals_next;

    // response register
    logic                 rsp_valid_reg;
    logic [STAT_W-1:0]    rsp_status_reg;
    logic [SLOT_W-1:0]    rsp_slot_reg;
    logic [DEV_W-1:0]     rsp_dev_reg;
    logic [TIME_W-1:0]    rsp_time_reg;
    logic [CNT_OUT_W-1:0] rsp_active_reg;
    logic [TOTAL_W-1:0]   rsp_created_reg;
    logic [TOTAL_W-1:0]   rsp_signaled_reg;

    // request side
    logic              req_fire;
    logic              free_found;
    logic [ROW_AW-1:0] free_row;
    logic [IDX_W-1:0]  sid_idx;
    logic [ROW_AW-1:0] rd_row;
    logic              in_range;

    // execute side
    logic              exec_fire;
    logic [IDX_W-1:0]  sid_idx_reg;
    logic [ROW_BW-1:0] sid_bit;
    logic [ROW_W-1:0]  row_data;
    logic [ROW_W-1:0]  pad_mask;
    logic [ROW_W-1:0]  row_busy;
    logic [ROW_BW-1:0] free_bit;
    logic [IDX_W-1:0]  new_idx;
    logic              slot_ok;
    logic [ROW_W-1:0]  row_new;
    logic              row_wr;
    logic              ent_wr;
    logic [SLOT_AW-1:0] ent_addr;
    entry_t            ent_data;
    logic [STAT_W-1:0] stat_c;
    logic [SLOT_W-1:0] rslot_c;
    logic [DEV_W-1:0]  rdev_c;
    logic [TIME_W-1:0] rtime_c;

    // one request in flight at a time, so the write-back never overlaps the next read
    assign req_stall = (state_reg != S_IDLE);
    assign req_fire  = req_valid && !req_stall;
    assign exec_fire = (state_reg == S_EXEC) && (!rsp_valid_reg || !rsp_stall);

    // lowest row that still has a free slot
    always_comb
    begin
        free_found = 1'b0;
        free_row   = '0;
        for (int r = ROWS - 1; r >= 0; r--)
        begin
            if (!row_full_reg[r])
            begin
                free_found = 1'b1;
                free_row   = ROW_AW'(r);
            end
        end
    end

    assign sid_idx  = IDX_W'(slot_id);
    assign in_range = ({24'd0, slot_id} < 32'(NUM_SLOTS));
    assign rd_row   = (action == ACT_CREATE) ? free_row : sid_idx[IDX_W-1:ROW_BW];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (exec_fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // request capture and memory reads
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            act_reg        <= action;
            sid_reg        <= slot_id;
            dev_reg        <= owner_device;
            now_reg        <= time_now;
            in_range_reg   <= in_range;
            free_found_reg <= free_found;
            row_addr_reg   <= rd_row;
            row_live_reg   <= row_init_reg[rd_row];
            row_rd_reg     <= row_mem[rd_row];
            entry_rd_reg   <= entry_mem[sid_idx[SLOT_AW-1:0]];
        end
    end

    // execute: modify the row and entry that were read
    assign sid_idx_reg = IDX_W'(sid_reg);
    assign sid_bit     = sid_reg[ROW_BW-1:0];
    assign row_data    = row_live_reg ? row_rd_reg : '0;

    // slots past the end of the table count as taken
    always_comb
    begin
        for (int b = 0; b < ROW_W; b++)
        begin
            pad_mask[b] = ((int'(row_addr_reg) * ROW_W + b) >= NUM_SLOTS);
        end
    end

    assign row_busy = row_data | pad_mask;

    always_comb
    begin
        free_bit = '0;
        for (int b = ROW_W - 1; b >= 0; b--)
        begin
            if (!row_busy[b])
            begin
                free_bit = ROW_BW'(b);
            end
        end
    end

    assign new_idx = {row_addr_reg, free_bit};
    assign slot_ok = in_range_reg && row_data[sid_bit];

    always_comb
    begin
        stat_c       = STAT_INVALID;
        rslot_c      = sid_reg;
        rdev_c       = '0;
        rtime_c      = '0;
        active_next  = active_reg;
        creates_next = creates_reg;
        signals_next = signals_reg;
        row_new      = row_data;
        row_wr       = 1'b0;
        ent_wr       = 1'b0;
        ent_addr     = sid_idx_reg[SLOT_AW-1:0];
        ent_data     = entry_rd_reg;
        unique case (act_reg)
            ACT_CREATE:
            begin
                if (free_found_reg)
                begin
                    row_new[free_bit] = 1'b1;
                    row_wr            = 1'b1;
                    ent_wr            = 1'b1;
                    ent_addr          = new_idx[SLOT_AW-1:0];
                    ent_data.signaled = 1'b0;
                    ent_data.owner    = dev_reg;
                    ent_data.stamp    = now_reg;
                    active_next       = active_reg + 1'b1;
                    creates_next      = creates_reg + 1'b1;
                    stat_c            = STAT_OK;
                    rslot_c           = SLOT_W'(new_idx);
                    rdev_c            = dev_reg;
                    rtime_c           = now_reg;
                end
                else
                begin
                    stat_c  = STAT_FULL;
                    rslot_c = '0;
                end
            end
            ACT_DESTROY:
            begin
                if (slot_ok)
                begin
                    row_new[sid_bit] = 1'b0;
                    row_wr           = 1'b1;
                    active_next      = active_reg - 1'b1;
                    stat_c           = STAT_OK;
                    rdev_c           = entry_rd_reg.owner;
                    rtime_c          = entry_rd_reg.stamp;
                end
            end
            ACT_SIGNAL:
            begin
                if (slot_ok)
                begin
                    ent_wr            = 1'b1;
                    ent_data.signaled = 1'b1;
                    ent_data.stamp    = now_reg;
                    signals_next      = signals_reg + 1'b1;
                    stat_c            = STAT_OK;
                    rdev_c            = entry_rd_reg.owner;
                    rtime_c           = now_reg;
                end
            end
            ACT_QUERY:
            begin
                if (slot_ok)
                begin
                    stat_c  = entry_rd_reg.signaled ? STAT_OK : STAT_PENDING;
                    rdev_c  = entry_rd_reg.owner;
                    rtime_c = entry_rd_reg.stamp;
                end
            end
            default:
            begin
                stat_c = STAT_INVALID;
            end
        endcase
    end

    // write-back
    always_ff @(posedge clk)
    begin
        if (exec_fire && row_wr)
        begin
            row_mem[row_addr_reg] <= row_new;
        end
        if (exec_fire && ent_wr)
        begin
            entry_mem[ent_addr] <= ent_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_full_reg <= '0;
            row_init_reg <= '0;
            active_reg   <= '0;
            creates_reg  <= '0;
            signals_reg  <= '0;
        end
        else if (exec_fire)
        begin
            if (row_wr)
            begin
                row_full_reg[row_addr_reg] <= &(row_new | pad_mask);
                row_init_reg[row_addr_reg] <= 1'b1;
            end
            active_reg  <= active_next;
            creates_reg <= creates_next;
            signals_reg <= signals_next;
        end
    end

    // response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (exec_fire)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec_fire)
        begin
            rsp_status_reg   <= stat_c;
            rsp_slot_reg     <= rslot_c;
            rsp_dev_reg      <= rdev_c;
            rsp_time_reg     <= rtime_c;
            rsp_active_reg   <= CNT_OUT_W'(active_next);
            rsp_created_reg  <= creates_next;
            rsp_signaled_reg <= signals_next;
        end
    end

    assign rsp_valid      = rsp_valid_reg;
    assign status         = rsp_status_reg;
    assign result_slot    = rsp_slot_reg;
    assign slot_device    = rsp_dev_reg;
    assign slot_time      = rsp_time_reg;
    assign active_count   = rsp_active_reg;
    assign created_total  = rsp_created_reg;
    assign signaled_total = rsp_signaled_reg;

    // checks
    a_active_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(active_reg) <= 32'(NUM_SLOTS))
        else $error("active count above table size");

    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> (state_reg == S_EXEC) && req_stall)
        else $error("transfer not followed by write-back cycle");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        exec_fire && (act_reg == ACT_CREATE) && !free_found_reg
        |=> rsp_valid && (status == STAT_FULL))
        else $error("create without free row must answer full");

    a_full_rows_written: assert property (@(posedge clk) disable iff (!rst_n)
        (row_full_reg & ~row_init_reg) == '0)
        else $error("row marked full but never written");

    a_empty_has_free: assert property (@(posedge clk) disable iff (!rst_n)
        (active_reg == '0) |-> !(&row_full_reg))
        else $error("empty table reports no free row");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// self-checking testbench for the event slot table: request driver, response monitor, predictor
`timescale 1ns / 1ps

module tb;
    import est_pkg::*;

    localparam int SLOTS        = DEFAULT_NUM_SLOTS;
    localparam int RANDOM_ITEMS = 1800;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_START   = 3000;
    localparam int HOLD_LEN     = 300;
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        logic [ACT_W-1:0]  action;
        logic [SLOT_W-1:0] slot;
        logic [DEV_W-1:0]  device;
        logic [TIME_W-1:0] stamp;
    } event_req_t;

    typedef struct {
        logic [STAT_W-1:0]    status;
        logic [SLOT_W-1:0]    slot;
        logic [DEV_W-1:0]     device;
        logic [TIME_W-1:0]    stamp;
        logic [CNT_OUT_W-1:0] active;
        logic [TOTAL_W-1:0]   created;
        logic [TOTAL_W-1:0]   signaled;
    } event_rsp_t;

    typedef enum int {RX_OPEN, RX_COIN, RX_CHOKED, RX_PERIODIC} rx_pattern_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic              req_valid = 1'b0;
    logic              req_stall;
    logic [ACT_W-1:0]  action = ACT_CREATE;
    logic [SLOT_W-1:0] slot_id = '0;
    logic [DEV_W-1:0]  owner_device = '0;
    logic [TIME_W-1:0] time_now = '0;

    logic                 rsp_valid;
    logic                 rsp_stall = 1'b0;
    logic [STAT_W-1:0]    status;
    logic [SLOT_W-1:0]    result_slot;
    logic [DEV_W-1:0]     slot_device;
    logic [TIME_W-1:0]    slot_time;
    logic [CNT_OUT_W-1:0] active_count;
    logic [TOTAL_W-1:0]   created_total;
    logic [TOTAL_W-1:0]   signaled_total;

    event_slot_table #(.NUM_SLOTS(SLOTS)) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .action         (action),
        .slot_id        (slot_id),
        .owner_device   (owner_device),
        .time_now       (time_now),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .status         (status),
        .result_slot    (result_slot),
        .slot_device    (slot_device),
        .slot_time      (slot_time),
        .active_count   (active_count),
        .created_total  (created_total),
        .signaled_total (signaled_total)
    );

    // predicted table contents, updated at each request transfer
    logic               tbl_live [SLOTS];
    logic               tbl_signaled [SLOTS];
    logic [DEV_W-1:0]   tbl_owner [SLOTS];
    logic [TIME_W-1:0]  tbl_stamp [SLOTS];
    int                 live_events = 0;
    logic [TOTAL_W-1:0] creates_total = '0;
    logic [TOTAL_W-1:0] signals_total = '0;

    // occupancy as seen by the stimulus generator, so requests can target live slots
    logic plan_live [SLOTS];
    int   plan_count = 0;

    event_req_t pending_requests[$];
    event_rsp_t expected_responses[$];
    event_req_t offered;

    int items_queued = 0;
    int items_accepted = 0;
    int mismatches = 0;
    int cycle_count = 0;
    int burst_left = 0;
    int gap_left = 0;
    int stall_clock = 0;
    int stall_mode_left = 0;
    rx_pattern_t stall_mode = RX_OPEN;

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic event_rsp_t table_outcome(event_req_t r);
        event_rsp_t o;
        int free_idx;
        int i;
        free_idx = -1;
        o.status = STAT_INVALID;
        o.slot = r.slot;
        o.device = '0;
        o.stamp = '0;
        if (r.action == ACT_CREATE)
        begin
            for (i = SLOTS - 1; i >= 0; i--)
                if (!tbl_live[i])
                    free_idx = i;
            if (free_idx >= 0)
            begin
                tbl_live[free_idx] = 1'b1;
                tbl_signaled[free_idx] = 1'b0;
                tbl_owner[free_idx] = r.device;
                tbl_stamp[free_idx] = r.stamp;
                live_events++;
                creates_total++;
                o.status = STAT_OK;
                o.slot = SLOT_W'(free_idx);
                o.device = r.device;
                o.stamp = r.stamp;
            end
            else
            begin
                o.status = STAT_FULL;
                o.slot = '0;
            end
        end
        else if (int'(r.slot) < SLOTS && tbl_live[r.slot])
        begin
            case (r.action)
                ACT_DESTROY:
                begin
                    tbl_live[r.slot] = 1'b0;
                    live_events--;
                    o.status = STAT_OK;
                end
                ACT_SIGNAL:
                begin
                    tbl_signaled[r.slot] = 1'b1;
                    tbl_stamp[r.slot] = r.stamp;
                    signals_total++;
                    o.status = STAT_OK;
                end
                default:
                    o.status = tbl_signaled[r.slot] ? STAT_OK : STAT_PENDING;
            endcase
            o.device = tbl_owner[r.slot];
            o.stamp = tbl_stamp[r.slot];
        end
        o.active = CNT_OUT_W'(live_events);
        o.created = creates_total;
        o.signaled = signals_total;
        return o;
    endfunction

    function automatic void queue_request(logic [ACT_W-1:0] act, logic [SLOT_W-1:0] sid,
                                          logic [DEV_W-1:0] dev, logic [TIME_W-1:0] stamp);
        event_req_t r;
        int i;
        r.action = act;
        r.slot = sid;
        r.device = dev;
        r.stamp = stamp;
        if (act == ACT_CREATE)
        begin
            for (i = 0; i < SLOTS; i++)
                if (!plan_live[i])
                begin
                    plan_live[i] = 1'b1;
                    plan_count++;
                    break;
                end
        end
        else if (act == ACT_DESTROY && plan_live[sid])
        begin
            plan_live[sid] = 1'b0;
            plan_count--;
        end
        pending_requests.push_back(r);
        items_queued++;
    endfunction

    function automatic logic [SLOT_W-1:0] pick_slot(int live_pct);
        int start;
        int k;
        start = $urandom_range(0, SLOTS - 1);
        if (plan_count > 0 && $urandom_range(0, 99) < live_pct)
            for (k = 0; k < SLOTS; k++)
                if (plan_live[(start + k) % SLOTS])
                    return SLOT_W'((start + k) % SLOTS);
        return SLOT_W'(start);
    endfunction

    function automatic logic [TIME_W-1:0] random_stamp();
        int roll;
        roll = $urandom_range(0, 15);
        if (roll == 0)
            return '0;
        if (roll == 1)
            return '1;
        return {$urandom, $urandom};
    endfunction

    // weights in percent; query takes what is left
    function automatic void queue_random(int create_w, int destroy_w, int signal_w, int live_pct);
        int roll;
        logic [ACT_W-1:0] act;
        roll = $urandom_range(0, 99);
        if (roll < create_w)
            act = ACT_CREATE;
        else if (roll < create_w + destroy_w)
            act = ACT_DESTROY;
        else if (roll < create_w + destroy_w + signal_w)
            act = ACT_SIGNAL;
        else
            act = ACT_QUERY;
        queue_request(act, pick_slot(live_pct), DEV_W'($urandom_range(0, 255)), random_stamp());
    endfunction

    initial
    begin
        int phase_len;
        // predictor and plan start empty before any request is queued
        for (int i = 0; i < SLOTS; i++)
        begin
            tbl_live[i] = 1'b0;
            tbl_signaled[i] = 1'b0;
            tbl_owner[i] = '0;
            tbl_stamp[i] = '0;
            plan_live[i] = 1'b0;
        end

        // empty table, lowest free reuse, signal and re-signal, double destroy
        queue_request(ACT_QUERY, 8'd0, 8'd0, '0);
        queue_request(ACT_DESTROY, 8'd255, 8'd255, '1);
        queue_request(ACT_SIGNAL, 8'd128, 8'd1, 64'h1234);
        queue_request(ACT_CREATE, 8'd0, 8'd0, '0);
        queue_request(ACT_CREATE, 8'd255, 8'd255, '1);
        queue_request(ACT_CREATE, 8'd7, 8'h5a, 64'h8000_0000_0000_0001);
        queue_request(ACT_QUERY, 8'd0, 8'd0, '0);
        queue_request(ACT_SIGNAL, 8'd0, 8'd3, '1);
        queue_request(ACT_QUERY, 8'd0, 8'd0, '0);
        queue_request(ACT_SIGNAL, 8'd0, 8'd3, '0);
        queue_request(ACT_DESTROY, 8'd1, 8'd0, '0);
        queue_request(ACT_QUERY, 8'd1, 8'd0, '0);
        queue_request(ACT_DESTROY, 8'd1, 8'd0, '0);
        queue_request(ACT_SIGNAL, 8'd2, 8'd0, 64'h0123_4567_89ab_cdef);
        queue_request(ACT_DESTROY, 8'd2, 8'd0, '0);
        queue_request(ACT_CREATE, 8'd200, 8'h81, 64'hfedc_ba98_7654_3210);
        queue_request(ACT_CREATE, 8'd100, 8'h7e, 64'h5555_aaaa_5555_aaaa);
        queue_request(ACT_QUERY, 8'd2, 8'd0, '0);
        queue_request(ACT_DESTROY, 8'd0, 8'd0, '0);
        queue_request(ACT_QUERY, 8'd255, 8'd0, '0);
        queue_request(ACT_SIGNAL, 8'd1, 8'd0, 64'haaaa_5555_aaaa_5555);

        // fill the table, then keep creating against a full table
        while (plan_count < SLOTS)
            queue_random(60, 10, 15, 90);
        repeat (30)
            queue_random(50, 5, 20, 90);

        while (items_queued < RANDOM_ITEMS)
        begin
            phase_len = $urandom_range(40, 250);
            case ($urandom_range(0, 3))
                0: repeat (phase_len) queue_random(60, 10, 15, 85);
                1: repeat (phase_len) queue_random(10, 50, 20, 85);
                2: repeat (phase_len) queue_random(30, 25, 25, 80);
                default: repeat (phase_len) queue_random(25, 25, 25, 0);
            endcase
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (items_accepted < items_queued || expected_responses.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_responses.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    always @(posedge clk)
        cycle_count++;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    // request driver: bursts of transfers separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                expected_responses.push_back(table_outcome(offered));
                items_accepted++;
            end
            if (!req_valid || !req_stall)
            begin
                if (gap_left > 0 || pending_requests.size() == 0)
                begin
                    if (gap_left > 0)
                        gap_left--;
                    req_valid <= 1'b0;
                end
                else
                begin
                    offered = pending_requests.pop_front();
                    action <= offered.action;
                    slot_id <= offered.slot;
                    owner_device <= offered.device;
                    time_now <= offered.stamp;
                    req_valid <= 1'b1;
                    if (burst_left > 0)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(0, 31);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end
            end
        end
    end

    // response stall pattern, with one long hold-off so the request side backs up
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
        end
        else
        begin
            stall_clock++;
            if (stall_clock >= HOLD_START && stall_clock < HOLD_START + HOLD_LEN)
            begin
                rsp_stall <= 1'b1;
            end
            else
            begin
                if (stall_mode_left == 0)
                begin
                    stall_mode = rx_pattern_t'($urandom_range(0, 3));
                    stall_mode_left = $urandom_range(16, 128);
                end
                else
                begin
                    stall_mode_left--;
                end
                case (stall_mode)
                    RX_OPEN:     rsp_stall <= 1'b0;
                    RX_COIN:     rsp_stall <= 1'($urandom_range(0, 1));
                    RX_CHOKED:   rsp_stall <= ($urandom_range(0, 3) != 0);
                    default:     rsp_stall <= (stall_clock % 3 == 0);
                endcase
            end
        end
    end

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // response monitor
    always @(posedge clk)
    begin
        event_rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_responses.size() == 0)
            begin
                $display("%0t: response transfer with none expected, status %0h slot %0h",
                         $time, status, result_slot);
                mismatches++;
            end
            else
            begin
                want = expected_responses.pop_front();
                check_field("status", 64'(want.status), 64'(status));
                check_field("result_slot", 64'(want.slot), 64'(result_slot));
                check_field("slot_device", 64'(want.device), 64'(slot_device));
                check_field("slot_time", want.stamp, slot_time);
                check_field("active_count", 64'(want.active), 64'(active_count));
                check_field("created_total", 64'(want.created), 64'(created_total));
                check_field("signaled_total", 64'(want.signaled), 64'(signaled_total));
            end
        end
    end

endmodule
